[rtl/hsl_color_blend_pixel_top_macros.svh]
// ----------------------------------------------------------------------------
// HSL color blend assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef HSL_COLOR_BLEND_PIXEL_TOP_MACROS_SVH
`define HSL_COLOR_BLEND_PIXEL_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define HCB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define HCB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/hcb_pkg.sv]
// ----------------------------------------------------------------------------
// HSL color blend package
// Hue sector and hue region codes and pipeline stage counts.
// ----------------------------------------------------------------------------
package hcb_pkg;

    // channel holding the maximum of the layer color
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } hue_sec_t;

    // piece of the HSL to RGB transfer curve a channel falls on
    typedef enum logic [1:0] {
        RGN_RISE,
        RGN_TOP,
        RGN_FALL,
        RGN_LOW
    } hue_rgn_t;

    localparam int PRE_DIV_STAGES  = 8;
    localparam int POST_DIV_STAGES = 7;

endpackage

[rtl/hcb_div.sv]
// ----------------------------------------------------------------------------
// HSL color blend divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module hcb_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 16,
    parameter int QUO_W = 17
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    // upper NUM_W-QUO_W bits of num must be below den
    logic [DEN_W-1:0] rem_reg [1:QUO_W-1];
    logic [QUO_W-1:0] lo_reg  [1:QUO_W-1];
    logic [DEN_W-1:0] den_reg [1:QUO_W-1];
    logic [QUO_W-1:0] quo_reg [1:QUO_W];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_step
        logic [DEN_W-1:0] rem_cur;
        logic [DEN_W-1:0] den_cur;
        logic [QUO_W-1:0] lo_cur;
        logic [QUO_W-1:0] quo_cur;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             take;
        logic [DEN_W-1:0] rem_next;

        if (k == 0)
        begin : g_first
            assign rem_cur = num[NUM_W-1 -: DEN_W];
            assign lo_cur  = num[QUO_W-1:0];
            assign quo_cur = '0;
            assign den_cur = den;
        end
        else
        begin : g_rest
            assign rem_cur = rem_reg[k];
            assign lo_cur  = lo_reg[k];
            assign quo_cur = quo_reg[k];
            assign den_cur = den_reg[k];
        end

        assign trial    = {rem_cur, lo_cur[QUO_W-1]};
        assign take     = (trial >= {1'b0, den_cur});
        assign diff     = trial - {1'b0, den_cur};
        assign rem_next = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k+1] <= {quo_cur[QUO_W-2:0], take};
            end
        end

        if (k < QUO_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= rem_next;
                    lo_reg[k+1]  <= {lo_cur[QUO_W-2:0], 1'b0};
                    den_reg[k+1] <= den_cur;
                end
            end
        end
    end

    assign quo = quo_reg[QUO_W];

endmodule

[rtl/hsl_color_blend_pixel_top.sv]
// Throughput: one pixel per clock while no output stall holds the pipeline;
// three pipelined dividers, one quotient bit per stage.
// An output stall holds the whole pipeline; in_ready = !out_valid || out_ready.
// Reset clears all stage valid bits and sets opacity to full scale.
// ----------------------------------------------------------------------------
// HSL color blend pixel
// Color layer mode: base lightness with layer hue and saturation, mixed by alpha.
// ----------------------------------------------------------------------------
module hsl_color_blend_pixel_top
    import hcb_pkg::*;
#(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CHANNEL_BITS-1:0] cfg_wr_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [CHANNEL_BITS-1:0] base_red,
    input  logic [CHANNEL_BITS-1:0] base_green,
    input  logic [CHANNEL_BITS-1:0] base_blue,
    input  logic [CHANNEL_BITS-1:0] base_alpha,
    input  logic [CHANNEL_BITS-1:0] layer_red,
    input  logic [CHANNEL_BITS-1:0] layer_green,
    input  logic [CHANNEL_BITS-1:0] layer_blue,
    input  logic [CHANNEL_BITS-1:0] layer_alpha,
    input  logic [CHANNEL_BITS-1:0] mask_value,
    input  logic                    end_of_run,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [CHANNEL_BITS-1:0] out_red,
    output logic [CHANNEL_BITS-1:0] out_green,
    output logic [CHANNEL_BITS-1:0] out_blue,
    output logic [CHANNEL_BITS-1:0] out_alpha,
    output logic                    end_of_run_out
);

    localparam int W   = CHANNEL_BITS;
    localparam int PW  = 2 * W + 2;
    localparam int NW  = 2 * W + 1;
    localparam int Q   = W + 1;
    localparam int HW  = W + 3;
    localparam int TOT = PRE_DIV_STAGES + Q + POST_DIV_STAGES;

    localparam logic [W-1:0]  FULL    = {W{1'b1}};
    localparam logic [W-1:0]  HALF    = {1'b0, {(W-1){1'b1}}};
    localparam logic [HW-1:0] F_H     = {3'b000, FULL};
    localparam logic [HW-1:0] TWO_F   = F_H << 1;
    localparam logic [HW-1:0] THREE_F = F_H + TWO_F;
    localparam logic [HW-1:0] FOUR_F  = F_H << 2;
    localparam logic [HW-1:0] SIX_F   = TWO_F + FOUR_F;

    typedef struct packed {
        logic [2:0][W-1:0] rgb;
        logic [W-1:0]      a;
        logic              eor;
    } pix_t;

    typedef struct packed {
        logic [W-1:0] l;
        logic [W-1:0] delta;
        logic [W-1:0] den;
        logic [W-1:0] mag;
        hue_sec_t     sec;
        logic         neg;
        logic         grey;
    } lhs_t;

    typedef struct packed {
        pix_t              px;
        logic [2:0][W-1:0] lay;
        logic [W-1:0]      la;
        logic [W-1:0]      mask;
    } st1_t;

    typedef struct packed {
        pix_t           px;
        lhs_t           lh;
        logic [W-1:0]   mask;
        logic [2*W-1:0] prod;
    } st2_t;

    typedef struct packed {
        pix_t         px;
        lhs_t         lh;
        logic [W-1:0] mask;
        logic [W-1:0] comp;
    } st3_t;

    typedef struct packed {
        pix_t           px;
        lhs_t           lh;
        logic [2*W-1:0] prod;
    } st4_t;

    typedef struct packed {
        pix_t         px;
        lhs_t         lh;
        logic [W-1:0] comp;
    } st5_t;

    typedef struct packed {
        pix_t           px;
        lhs_t           lh;
        logic [W-1:0]   comp;
        logic [2*W-1:0] prod;
    } st6_t;

    typedef struct packed {
        pix_t         px;
        lhs_t         lh;
        logic [W-1:0] comp;
        logic [W-1:0] newa;
    } st7_t;

    typedef struct packed {
        pix_t         px;
        logic [W-1:0] l;
        hue_sec_t     sec;
        logic         neg;
        logic         flat;
        logic         bypass;
    } side_t;

    typedef struct packed {
        logic [NW-1:0] rn;
        logic [NW-1:0] sn;
        logic [NW-1:0] fn;
        logic [W-1:0]  rd;
        logic [W-1:0]  sd;
        logic [W-1:0]  fd;
    } dv_t;

    typedef struct packed {
        pix_t           px;
        logic           flat;
        logic           bypass;
        logic [W-1:0]   l;
        logic [W-1:0]   ratio;
        logic [HW-1:0]  h;
        logic [2*W-1:0] pm;
    } std_t;

    typedef struct packed {
        pix_t              px;
        logic              flat;
        logic              bypass;
        logic [W-1:0]      l;
        logic [W-1:0]      ratio;
        logic [W-1:0]      m2;
        hue_rgn_t [2:0]    rgn;
        logic [2:0][W-1:0] x;
    } ste_t;

    typedef struct packed {
        pix_t              px;
        logic              flat;
        logic              bypass;
        logic [W-1:0]      l;
        logic [W-1:0]      ratio;
        logic [W-1:0]      m1;
        logic [W-1:0]      m2;
        logic [W-1:0]      rise;
        hue_rgn_t [2:0]    rgn;
        logic [2:0][W-1:0] x;
    } stf_t;

    typedef struct packed {
        pix_t                pix;
        logic                flat;
        logic                bypass;
        logic [W-1:0]        l;
        logic [W-1:0]        ratio;
        logic [W-1:0]        m1;
        logic [W-1:0]        m2;
        hue_rgn_t [2:0]      rgn;
        logic [2:0][2*W-1:0] prod;
    } stg_t;

    typedef struct packed {
        pix_t              px;
        logic              bypass;
        logic [W-1:0]      ratio;
        logic [2:0][W-1:0] tint;
    } sth_t;

    typedef struct packed {
        pix_t              px;
        logic              bypass;
        logic [2:0][2*W:0] sum;
    } sti_t;

    // floor(n / FULL): reciprocal estimate, then one correction step
    function automatic logic [W:0] div_full(input logic [PW-1:0] n);
        logic [PW-1:0] q0;
        logic [PW-1:0] r;
        q0 = (n + (n >> W) + PW'(1)) >> W;
        r  = n - (q0 << W) + q0;
        if (r >= PW'(FULL))
        begin
            q0 = q0 + PW'(1);
        end
        return q0[W:0];
    endfunction

    function automatic logic [W-1:0] sat_w(input logic [W:0] x);
        return x[W] ? FULL : x[W-1:0];
    endfunction

    logic                adv;
    logic [W-1:0]        opacity_reg;
    logic [TOT-1:0]      v_reg;
    st1_t                s1_reg;
    st2_t                s2_reg,  s2_next;
    st3_t                s3_reg,  s3_next;
    st4_t                s4_reg,  s4_next;
    st5_t                s5_reg,  s5_next;
    st6_t                s6_reg,  s6_next;
    st7_t                s7_reg,  s7_next;
    side_t               side_reg [0:Q];
    side_t               side_next;
    dv_t                 dv_reg,  dv_next;
    std_t                sd_reg,  sd_next;
    ste_t                se_reg,  se_next;
    stf_t                sf_reg,  sf_next;
    stg_t                sg_reg,  sg_next;
    sth_t                sh_reg,  sh_next;
    sti_t                si_reg,  si_next;
    logic [2:0][W-1:0]   rgb_reg, rgb_next;
    logic [W-1:0]        alpha_reg;
    logic                eor_reg;
    logic [W:0]          q_ratio, q_sat, q_hue;

    assign adv      = !v_reg[TOT-1] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opacity_reg <= FULL;
        end
        else if (cfg_wr_en)
        begin
            opacity_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[TOT-2:0], in_valid};
        end
    end

    // stage 2: alpha product, layer extremes and hue setup, base lightness
    always_comb
    begin
        logic [W-1:0] min_a, lmx, lmn, bmx, bmn, hp, hq;
        logic [W:0]   lsum, bsum;
        logic [W:0]   two_f;
        two_f = {FULL, 1'b0};
        min_a = (s1_reg.px.a < s1_reg.la) ? s1_reg.px.a : s1_reg.la;
        lmx   = s1_reg.lay[0];
        lmn   = s1_reg.lay[0];
        bmx   = s1_reg.px.rgb[0];
        bmn   = s1_reg.px.rgb[0];
        for (int i = 1; i < 3; i++)
        begin
            if (s1_reg.lay[i] > lmx) lmx = s1_reg.lay[i];
            if (s1_reg.lay[i] < lmn) lmn = s1_reg.lay[i];
            if (s1_reg.px.rgb[i] > bmx) bmx = s1_reg.px.rgb[i];
            if (s1_reg.px.rgb[i] < bmn) bmn = s1_reg.px.rgb[i];
        end
        lsum = {1'b0, lmx} + {1'b0, lmn};
        bsum = {1'b0, bmx} + {1'b0, bmn} + (W+1)'(1);

        s2_next.px       = s1_reg.px;
        s2_next.mask     = s1_reg.mask;
        s2_next.prod     = min_a * opacity_reg;
        s2_next.lh.l     = bsum[W:1];
        s2_next.lh.delta = lmx - lmn;
        s2_next.lh.grey  = (lmx == lmn);
        s2_next.lh.den   = (lsum <= {1'b0, FULL}) ? lsum[W-1:0] : W'(two_f - lsum);
        // red maximum wins ties, then green
        if (s1_reg.lay[0] == lmx)
        begin
            s2_next.lh.sec = SEC_RED;
            hp = s1_reg.lay[1];
            hq = s1_reg.lay[2];
        end
        else if (s1_reg.lay[1] == lmx)
        begin
            s2_next.lh.sec = SEC_GREEN;
            hp = s1_reg.lay[2];
            hq = s1_reg.lay[0];
        end
        else
        begin
            s2_next.lh.sec = SEC_BLUE;
            hp = s1_reg.lay[0];
            hq = s1_reg.lay[1];
        end
        s2_next.lh.neg = (hp < hq);
        s2_next.lh.mag = (hp < hq) ? hq - hp : hp - hq;
    end

    always_comb
    begin
        s3_next.px   = s2_reg.px;
        s3_next.lh   = s2_reg.lh;
        s3_next.mask = s2_reg.mask;
        s3_next.comp = W'(div_full(PW'(s2_reg.prod) + PW'(HALF)));
    end

    always_comb
    begin
        s4_next.px   = s3_reg.px;
        s4_next.lh   = s3_reg.lh;
        s4_next.prod = s3_reg.comp * s3_reg.mask;
    end

    always_comb
    begin
        s5_next.px   = s4_reg.px;
        s5_next.lh   = s4_reg.lh;
        s5_next.comp = W'(div_full(PW'(s4_reg.prod) + PW'(HALF)));
    end

    always_comb
    begin
        s6_next.px   = s5_reg.px;
        s6_next.lh   = s5_reg.lh;
        s6_next.comp = s5_reg.comp;
        s6_next.prod = (FULL - s5_reg.px.a) * s5_reg.comp;
    end

    always_comb
    begin
        logic [W:0] add;
        add = {1'b0, s6_reg.px.a}
            + {1'b0, W'(div_full(PW'(s6_reg.prod) + PW'(HALF)))};
        s7_next.px   = s6_reg.px;
        s7_next.lh   = s6_reg.lh;
        s7_next.comp = s6_reg.comp;
        s7_next.newa = sat_w(add);
    end

    // stage 8: divider operands, n * FULL + d / 2 over d
    always_comb
    begin
        side_next.px     = s7_reg.px;
        side_next.l      = s7_reg.lh.l;
        side_next.sec    = s7_reg.lh.sec;
        side_next.neg    = s7_reg.lh.neg;
        side_next.flat   = s7_reg.lh.grey;
        side_next.bypass = (s7_reg.comp == '0) || (s7_reg.newa == '0);

        dv_next.rn = ({1'b0, s7_reg.comp, {W{1'b0}}} - NW'(s7_reg.comp))
                   + NW'(s7_reg.newa >> 1);
        dv_next.rd = s7_reg.newa;
        dv_next.sn = ({1'b0, s7_reg.lh.delta, {W{1'b0}}} - NW'(s7_reg.lh.delta))
                   + NW'(s7_reg.lh.den >> 1);
        dv_next.sd = s7_reg.lh.den;
        dv_next.fn = ({1'b0, s7_reg.lh.mag, {W{1'b0}}} - NW'(s7_reg.lh.mag))
                   + NW'(s7_reg.lh.delta >> 1);
        dv_next.fd = s7_reg.lh.delta;
    end

    hcb_div #(.NUM_W(NW), .DEN_W(W), .QUO_W(Q)) u_div_ratio (
        .clk (clk),
        .en  (adv),
        .num (dv_reg.rn),
        .den (dv_reg.rd),
        .quo (q_ratio)
    );

    hcb_div #(.NUM_W(NW), .DEN_W(W), .QUO_W(Q)) u_div_sat (
        .clk (clk),
        .en  (adv),
        .num (dv_reg.sn),
        .den (dv_reg.sd),
        .quo (q_sat)
    );

    hcb_div #(.NUM_W(NW), .DEN_W(W), .QUO_W(Q)) u_div_hue (
        .clk (clk),
        .en  (adv),
        .num (dv_reg.fn),
        .den (dv_reg.fd),
        .quo (q_hue)
    );

    // after the dividers: hue in sextants, lightness scale product
    always_comb
    begin
        logic [W-1:0]  s, f, mul_b;
        logic [HW-1:0] base_h, f_h;
        s   = sat_w(q_sat);
        f   = sat_w(q_hue);
        f_h = {3'b000, f};
        case (side_reg[Q].sec)
            SEC_GREEN: base_h = TWO_F;
            SEC_BLUE:  base_h = FOUR_F;
            default:   base_h = '0;
        endcase
        sd_next.px     = side_reg[Q].px;
        sd_next.bypass = side_reg[Q].bypass;
        sd_next.flat   = side_reg[Q].flat || (s == '0);
        sd_next.l      = side_reg[Q].l;
        sd_next.ratio  = sat_w(q_ratio);
        if (!side_reg[Q].neg)
        begin
            sd_next.h = base_h + f_h;
        end
        else if (base_h >= f_h)
        begin
            sd_next.h = base_h - f_h;
        end
        else
        begin
            sd_next.h = SIX_F - f_h;
        end
        mul_b = ({side_reg[Q].l, 1'b0} <= {1'b0, FULL}) ? side_reg[Q].l
                                                         : FULL - side_reg[Q].l;
        sd_next.pm = s * mul_b;
    end

    always_comb
    begin
        logic [HW-1:0] hc [0:2];
        logic [HW-1:0] hr;
        logic [W:0]    add;
        add = {1'b0, sd_reg.l} + {1'b0, W'(div_full(PW'(sd_reg.pm) + PW'(HALF)))};
        hr  = sd_reg.h + TWO_F;
        hc[0] = (hr >= SIX_F) ? hr - SIX_F : hr;
        hc[1] = sd_reg.h;
        hc[2] = (sd_reg.h >= TWO_F) ? sd_reg.h - TWO_F : sd_reg.h + FOUR_F;

        se_next.px     = sd_reg.px;
        se_next.flat   = sd_reg.flat;
        se_next.bypass = sd_reg.bypass;
        se_next.l      = sd_reg.l;
        se_next.ratio  = sd_reg.ratio;
        se_next.m2     = sat_w(add);
        for (int c = 0; c < 3; c++)
        begin
            if (hc[c] < F_H)
            begin
                se_next.rgn[c] = RGN_RISE;
                se_next.x[c]   = hc[c][W-1:0];
            end
            else if (hc[c] < THREE_F)
            begin
                se_next.rgn[c] = RGN_TOP;
                se_next.x[c]   = '0;
            end
            else if (hc[c] < FOUR_F)
            begin
                se_next.rgn[c] = RGN_FALL;
                se_next.x[c]   = W'(FOUR_F - hc[c]);
            end
            else
            begin
                se_next.rgn[c] = RGN_LOW;
                se_next.x[c]   = '0;
            end
        end
    end

    always_comb
    begin
        logic [W:0]   two_l;
        logic [W:0]   m1w;
        logic [W-1:0] m1;
        two_l = {se_reg.l, 1'b0};
        m1w   = (two_l > {1'b0, se_reg.m2}) ? two_l - {1'b0, se_reg.m2} : '0;
        m1    = (m1w > {1'b0, se_reg.m2}) ? se_reg.m2 : m1w[W-1:0];

        sf_next.px     = se_reg.px;
        sf_next.flat   = se_reg.flat;
        sf_next.bypass = se_reg.bypass;
        sf_next.l      = se_reg.l;
        sf_next.ratio  = se_reg.ratio;
        sf_next.m1     = m1;
        sf_next.m2     = se_reg.m2;
        sf_next.rise   = se_reg.m2 - m1;
        sf_next.rgn    = se_reg.rgn;
        sf_next.x      = se_reg.x;
    end

    always_comb
    begin
        sg_next.pix    = sf_reg.px;
        sg_next.flat   = sf_reg.flat;
        sg_next.bypass = sf_reg.bypass;
        sg_next.l      = sf_reg.l;
        sg_next.ratio  = sf_reg.ratio;
        sg_next.m1     = sf_reg.m1;
        sg_next.m2     = sf_reg.m2;
        sg_next.rgn    = sf_reg.rgn;
        for (int c = 0; c < 3; c++)
        begin
            sg_next.prod[c] = sf_reg.rise * sf_reg.x[c];
        end
    end

    always_comb
    begin
        logic [W:0] ramp;
        sh_next.px     = sg_reg.pix;
        sh_next.bypass = sg_reg.bypass;
        sh_next.ratio  = sg_reg.ratio;
        for (int c = 0; c < 3; c++)
        begin
            ramp = {1'b0, sg_reg.m1}
                 + {1'b0, W'(div_full(PW'(sg_reg.prod[c]) + PW'(HALF)))};
            case (sg_reg.rgn[c])
                RGN_RISE, RGN_FALL: sh_next.tint[c] = sat_w(ramp);
                RGN_TOP:            sh_next.tint[c] = sg_reg.m2;
                default:            sh_next.tint[c] = sg_reg.m1;
            endcase
            // layer without saturation: grey at base lightness
            if (sg_reg.flat)
            begin
                sh_next.tint[c] = sg_reg.l;
            end
        end
    end

    always_comb
    begin
        logic [2*W-1:0] pt, pb;
        si_next.px     = sh_reg.px;
        si_next.bypass = sh_reg.bypass;
        for (int c = 0; c < 3; c++)
        begin
            pt = sh_reg.tint[c] * sh_reg.ratio;
            pb = sh_reg.px.rgb[c] * (FULL - sh_reg.ratio);
            si_next.sum[c] = {1'b0, pt} + {1'b0, pb} + (2*W+1)'(HALF);
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            rgb_next[c] = si_reg.bypass ? si_reg.px.rgb[c]
                                        : sat_w(div_full(PW'(si_reg.sum[c])));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg.px.rgb <= {base_blue, base_green, base_red};
            s1_reg.px.a   <= base_alpha;
            s1_reg.px.eor <= end_of_run;
            s1_reg.lay    <= {layer_blue, layer_green, layer_red};
            s1_reg.la     <= layer_alpha;
            s1_reg.mask   <= mask_value;
            s2_reg        <= s2_next;
            s3_reg        <= s3_next;
            s4_reg        <= s4_next;
            s5_reg        <= s5_next;
            s6_reg        <= s6_next;
            s7_reg        <= s7_next;
            side_reg[0]   <= side_next;
            dv_reg        <= dv_next;
            for (int k = 1; k <= Q; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            sd_reg        <= sd_next;
            se_reg        <= se_next;
            sf_reg        <= sf_next;
            sg_reg        <= sg_next;
            sh_reg        <= sh_next;
            si_reg        <= si_next;
            rgb_reg       <= rgb_next;
            alpha_reg     <= si_reg.px.a;
            eor_reg       <= si_reg.px.eor;
        end
    end

    assign out_valid      = v_reg[TOT-1];
    assign out_red        = rgb_reg[0];
    assign out_green      = rgb_reg[1];
    assign out_blue       = rgb_reg[2];
    assign out_alpha      = alpha_reg;
    assign end_of_run_out = eor_reg;

endmodule

[rtl/hcb_checker.sv]
// ----------------------------------------------------------------------------
// HSL color blend checker
// Port-level checks on stall behavior, bound to the top level.
// ----------------------------------------------------------------------------
`include "hsl_color_blend_pixel_top_macros.svh"

module hcb_checker #(
    parameter int CHANNEL_BITS = 16
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [CHANNEL_BITS-1:0] out_red,
    input logic [CHANNEL_BITS-1:0] out_green,
    input logic [CHANNEL_BITS-1:0] out_blue,
    input logic [CHANNEL_BITS-1:0] out_alpha
);

    // a held result freezes the pipe, so no new transfer may enter
    `HCB_ASSERT_IMP(a_stall_blocks_input, out_valid && !out_ready, !in_ready, "input taken during output stall")

    // a free output slot must let the pipe move
    `HCB_ASSERT_IMP(a_free_out_takes_input, !out_valid || out_ready, in_ready, "pipe stuck with free output")

    `HCB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_alpha), "stalled result changed")

endmodule

bind hsl_color_blend_pixel_top hcb_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_hcb_checker (.*);

[bench/hsl_color_blend_pixel_top_test.sv]
// ----------------------------------------------------------------------------
// HSL color blend pixel testbench
// Drives pixels through the valid/ready ports with random gaps and stalls.
// A local model predicts every output pixel, and the scoreboard checks each
// output in order. Opacity is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
    logic        eor;
} blend_px_t;

class blend_scoreboard;
    localparam longint FULL = 65535;
    blend_px_t   pending[$];
    logic [15:0] opacity = 16'hFFFF;
    int          mismatches = 0;

    function longint fmul(longint a, longint b);
        return (a * b + FULL / 2) / FULL;
    endfunction

    function longint fdiv(longint n, longint d);
        if (d == 0)
            return FULL;
        return (n + d / 2) / d;
    endfunction

    function longint clip(longint v);
        return (v > FULL) ? FULL : v;
    endfunction

    // one channel of the HSL to RGB curve
    function longint hsl_chan(longint m1, longint m2, longint h);
        longint rise;
        rise = (m2 >= m1) ? m2 - m1 : 0;
        if (h < 0)
            h += 6 * FULL;
        if (h >= 6 * FULL)
            h -= 6 * FULL;
        if (h < FULL)
            return clip(m1 + fdiv(rise * h, FULL));
        if (h < 3 * FULL)
            return m2;
        if (h < 4 * FULL)
            return clip(m1 + fdiv(rise * (4 * FULL - h), FULL));
        return m1;
    endfunction

    function blend_px_t blend(logic [15:0] b[3], logic [15:0] ba, logic [15:0] l[3],
                              logic [15:0] la, logic [15:0] mask, logic eor);
        blend_px_t r;
        longint comp, newa, ratio, mx, mn, lt, s, m1, m2, dl, sum, d, mag, f, h;
        longint tint[3], res[3];
        int sector;
        for (int i = 0; i < 3; i++)
            res[i] = b[i];
        comp = fmul(fmul((ba < la) ? ba : la, opacity), mask);
        newa = clip(ba + fmul(FULL - ba, comp));
        if (comp != 0 && newa != 0)
        begin
            ratio = clip(fdiv(comp * FULL, newa));
            mx = l[0]; mn = l[0];
            for (int i = 1; i < 3; i++)
            begin
                if (l[i] > mx) mx = l[i];
                if (l[i] < mn) mn = l[i];
            end
            dl = mx - mn;
            s = 0; h = 0;
            if (dl != 0)
            begin
                sum = mx + mn;
                s = clip(fdiv(dl * FULL, (sum <= FULL) ? sum : 2 * FULL - sum));
                if (l[0] == mx)
                begin
                    d = longint'(l[1]) - l[2]; sector = 0;
                end
                else if (l[1] == mx)
                begin
                    d = longint'(l[2]) - l[0]; sector = 2;
                end
                else
                begin
                    d = longint'(l[0]) - l[1]; sector = 4;
                end
                mag = (d < 0) ? -d : d;
                f = fdiv(mag * FULL, dl);
                h = sector * FULL + ((d < 0) ? -f : f);
                if (h < 0)
                    h += 6 * FULL;
            end
            mx = b[0]; mn = b[0];
            for (int i = 1; i < 3; i++)
            begin
                if (b[i] > mx) mx = b[i];
                if (b[i] < mn) mn = b[i];
            end
            lt = (mx + mn + 1) / 2;
            if (s == 0)
            begin
                for (int i = 0; i < 3; i++)
                    tint[i] = lt;
            end
            else
            begin
                m2 = clip((2 * lt <= FULL) ? lt + fmul(lt, s) : lt + fmul(s, FULL - lt));
                m1 = (2 * lt > m2) ? 2 * lt - m2 : 0;
                if (m1 > m2)
                    m1 = m2;
                tint[0] = hsl_chan(m1, m2, h + 2 * FULL);
                tint[1] = hsl_chan(m1, m2, h);
                tint[2] = hsl_chan(m1, m2, h - 2 * FULL);
            end
            for (int i = 0; i < 3; i++)
                res[i] = clip((tint[i] * ratio + b[i] * (FULL - ratio) + FULL / 2) / FULL);
        end
        r.red = 16'(res[0]); r.green = 16'(res[1]); r.blue = 16'(res[2]);
        r.alpha = ba; r.eor = eor;
        return r;
    endfunction

    function void note_input(logic [15:0] b[3], logic [15:0] ba, logic [15:0] l[3],
                             logic [15:0] la, logic [15:0] mask, logic eor);
        pending.push_back(blend(b, ba, l, la, mask, eor));
    endfunction

    function void check_output(blend_px_t got);
        blend_px_t want;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected output pixel %h", got);
            return;
        end
        want = pending.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("pixel mismatch: expected r=%h g=%h b=%h a=%h e=%b, got r=%h g=%h b=%h a=%h e=%b",
                         want.red, want.green, want.blue, want.alpha, want.eor,
                         got.red, got.green, got.blue, got.alpha, got.eor);
        end
    endfunction
endclass

module hsl_color_blend_pixel_top_test;
    import hcb_pkg::*;

    localparam int LIMIT = 2000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_wr_en = 0;
    logic [15:0] cfg_wr_data = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [15:0] base_red = 0, base_green = 0, base_blue = 0, base_alpha = 0;
    logic [15:0] layer_red = 0, layer_green = 0, layer_blue = 0, layer_alpha = 0;
    logic [15:0] mask_value = 0;
    logic        end_of_run = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [15:0] out_red, out_green, out_blue, out_alpha;
    logic        end_of_run_out;

    blend_scoreboard sb = new();
    bit  calm = 0;
    int  idle_cycles = 0;

    hsl_color_blend_pixel_top #(.CHANNEL_BITS(16)) u_top (.*);

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    // sample transfers and run the watchdog
    always @(posedge clk)
    begin
        logic [15:0] b[3], l[3];
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                b = '{base_red, base_green, base_blue};
                l = '{layer_red, layer_green, layer_blue};
                sb.note_input(b, base_alpha, l, layer_alpha, mask_value, end_of_run);
            end
            if (out_valid && out_ready)
                sb.check_output('{out_red, out_green, out_blue, out_alpha, end_of_run_out});
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= LIMIT)
            begin
                $display("hsl_color_blend_pixel_top_test NOT OK");
                $finish;
            end
        end
    end

    // receiver: random stall bursts
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 0;
                n = $urandom_range(1, 7);
                repeat (n) @(negedge clk);
            end
            out_ready <= 1;
        end
    end

    task automatic set_opacity(logic [15:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 0;
        sb.opacity = v;
    endtask

    task automatic send_pixel(logic [15:0] br, bg, bb, ba, lr, lg, lb, la, mk, logic eo);
        int n;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 0;
            n = $urandom_range(1, 7);
            repeat (n) @(negedge clk);
        end
        in_valid <= 1;
        base_red <= br; base_green <= bg; base_blue <= bb; base_alpha <= ba;
        layer_red <= lr; layer_green <= lg; layer_blue <= lb; layer_alpha <= la;
        mask_value <= mk; end_of_run <= eo;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 15));
            3: return 16'(16'hFFFF - $urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random();
        logic [15:0] g;
        g = pick16();
        case ($urandom_range(0, 7))
            // grey layer
            0: send_pixel(pick16(), pick16(), pick16(), pick16(), g, g, g,
                          pick16(), pick16(), 1'($urandom_range(0, 1)));
            // nothing to composite
            1: send_pixel(pick16(), pick16(), pick16(), pick16(), pick16(), pick16(),
                          pick16(), pick16(), 16'h0, 1'($urandom_range(0, 1)));
            // ties among layer channels
            2: send_pixel(pick16(), pick16(), pick16(), pick16(), g, g, pick16(),
                          pick16(), pick16(), 1'($urandom_range(0, 1)));
            default: send_pixel(16'($urandom), 16'($urandom), 16'($urandom), pick16(),
                                16'($urandom), 16'($urandom), 16'($urandom), pick16(),
                                pick16(), 1'($urandom_range(0, 1)));
        endcase
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    initial
    begin
        logic [15:0] opac[5];
        opac = '{16'hFFFF, 16'h0000, 16'h0001, 16'h8000, 16'hFFFE};
        repeat (7) @(negedge clk);
        rst_n = 1;

        // directed: reset opacity is full scale
        send_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
        send_pixel(16'h1234, 16'h8000, 16'hF000, 16'hFFFF, 16'hFFFF, 0, 0,
                   16'hFFFF, 16'hFFFF, 0);
        send_pixel(16'h1234, 16'h8000, 16'hF000, 16'h8000, 0, 16'hFFFF, 0,
                   16'hFFFF, 16'hFFFF, 1);
        send_pixel(16'hF000, 16'h8000, 16'h1234, 16'h4000, 0, 0, 16'hFFFF,
                   16'hFFFF, 16'h8000, 0);
        send_pixel(16'h0100, 16'h0200, 16'h0300, 16'h0001, 16'hFFFF, 0, 16'h0100,
                   16'h0001, 16'h0001, 1);
        send_pixel(16'hAAAA, 16'h5555, 16'h0000, 16'hFFFF, 16'h7777, 16'h7777,
                   16'h7777, 16'hFFFF, 16'hFFFF, 0);
        send_pixel(16'hFFFF, 16'h0000, 16'h8000, 0, 16'h8000, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 16'hFFFF, 0);
        send_pixel(16'h4000, 16'hC000, 16'h2000, 16'hFFFF, 16'hFFFF, 16'hFFFE,
                   16'h0000, 16'hFFFF, 16'hFFFF, 1);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFF, 16'h0001, 16'h0000,
                   16'h0002, 16'h8000, 16'hFFFF, 0);
        in_valid <= 0;
        drain();

        for (int p = 0; p < 5; p++)
        begin
            set_opacity(opac[p]);
            repeat (90) send_random();
            in_valid <= 0;
            drain();
        end
        for (int p = 0; p < 4; p++)
        begin
            set_opacity(16'($urandom));
            if (p == 3)
                calm = 1;
            repeat (100) send_random();
            in_valid <= 0;
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("hsl_color_blend_pixel_top_test OK");
        else
            $display("hsl_color_blend_pixel_top_test NOT OK");
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl
rtl/hcb_pkg.sv
rtl/hcb_div.sv
rtl/hsl_color_blend_pixel_top.sv
rtl/hcb_checker.sv
bench/hsl_color_blend_pixel_top_test.sv
